FILE: src/bfha_pkg.sv
// Package for the best-fit heap allocator: sizes, status codes, datapath
// op codes and the controller/datapath interface structs. No dependencies.
package bfha_pkg;

   localparam int HEAP_WORD_COUNT = 4096;
   localparam int WORD_W          = 16;
   localparam int AW              = $clog2(HEAP_WORD_COUNT);
   localparam int STORE_BYTES     = 4 * HEAP_WORD_COUNT;
   localparam int CAP_BYTES       = (STORE_BYTES / 8) * 8;
   // byte address wide enough for an in-store offset plus one block size
   localparam int ADDR_W          = (((AW + 2) > WORD_W) ? (AW + 2) : WORD_W) + 1;

   localparam int CFG_W      = 15;
   localparam int REQ_W      = 15;
   localparam int PTR_W      = 14;
   localparam int ST_W       = 3;
   localparam int RES_ADDR_W = 14;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam logic [ST_W-1:0] ST_OK           = 3'd0;
   localparam logic [ST_W-1:0] ST_BAD_SIZE     = 3'd1;
   localparam logic [ST_W-1:0] ST_NO_FIT       = 3'd2;
   localparam logic [ST_W-1:0] ST_BAD_PTR      = 3'd3;
   localparam logic [ST_W-1:0] ST_ALREADY_FREE = 3'd4;

   localparam int OP_W = 5;
   typedef logic [OP_W-1:0] dp_op_type;

   localparam dp_op_type OP_NONE      = 5'd0;
   localparam dp_op_type OP_FMT_CLR   = 5'd1;
   localparam dp_op_type OP_FMT_HDR   = 5'd2;
   localparam dp_op_type OP_FMT_FTR   = 5'd3;
   localparam dp_op_type OP_FMT_END   = 5'd4;
   localparam dp_op_type OP_LOAD      = 5'd5;
   localparam dp_op_type OP_RD_CUR    = 5'd6;
   localparam dp_op_type OP_A_CHK     = 5'd7;
   localparam dp_op_type OP_SPL_HDR   = 5'd8;
   localparam dp_op_type OP_SPL_REST  = 5'd9;
   localparam dp_op_type OP_SPL_FTR   = 5'd10;
   localparam dp_op_type OP_WR_BEST   = 5'd11;
   localparam dp_op_type OP_RD_ANX    = 5'd12;
   localparam dp_op_type OP_WR_ANX    = 5'd13;
   localparam dp_op_type OP_F_CHK     = 5'd14;
   localparam dp_op_type OP_RD_FNX    = 5'd15;
   localparam dp_op_type OP_F_NCHK    = 5'd16;
   localparam dp_op_type OP_RD_PFTR   = 5'd17;
   localparam dp_op_type OP_F_PCHK    = 5'd18;
   localparam dp_op_type OP_RD_START  = 5'd19;
   localparam dp_op_type OP_F_PBIT    = 5'd20;
   localparam dp_op_type OP_WR_START  = 5'd21;
   localparam dp_op_type OP_WR_SFTR   = 5'd22;
   localparam dp_op_type OP_RESULT    = 5'd23;

   typedef struct packed {
      dp_op_type       op;
      logic [ST_W-1:0] res_status;
   } dp_cmd_type;

   typedef struct packed {
      logic req_zero;
      logic ptr_bad;
      logic cmd_free;
      logic walk_stop;
      logic blk_free;
      logic exact;
      logic cur_gt;
      logic cur_eq;
      logic found;
      logic split;
      logic prev_merge;
      logic pbit_zero;
      logic fmt_last;
      logic out_busy;
   } dp_status_type;

endpackage

FILE: src/bfha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/bfha_datapath.sv
// Allocator datapath: heap store, walk registers, size register, result register.
// Depends on bfha_pkg and bfha_ram.
module bfha_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  bfha_pkg::dp_cmd_type          cmd,
   output bfha_pkg::dp_status_type       status,
   input  logic                          csr_wr_en,
   input  logic [bfha_pkg::CFG_W-1:0]    csr_wr_data,
   input  logic                          in_cmd,
   input  logic [bfha_pkg::REQ_W-1:0]    in_req_bytes,
   input  logic [bfha_pkg::PTR_W-1:0]    in_payload_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bfha_pkg::ST_W-1:0]     rsp_status,
   output logic [bfha_pkg::RES_ADDR_W-1:0] rsp_result_addr
);
   import bfha_pkg::*;

   logic [ADDR_W-1:0] heap_eff_ff, heap_eff_in;
   logic [AW-1:0]     fmt_cnt_ff, fmt_cnt_in;
   logic              cmd_ff, cmd_in;
   logic              req_zero_ff, req_zero_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [ADDR_W-1:0] need_ff, need_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] best_ff, best_in;
   logic [ADDR_W-1:0] bsz_ff, bsz_in;
   logic [WORD_W-1:0] bhdr_ff, bhdr_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] target_ff, target_in;
   logic [ADDR_W-1:0] total_ff, total_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic              pbit_ff, pbit_in;
   logic              rd_oob_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [RES_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic [ADDR_W-1:0] rd_byte, wr_byte, sz, eff_cfg, rest, psz;
   logic [WORD_W-1:0] h, wr_word, ram_q, nh;
   logic              wr_req, rd_ok, wr_ok, better;

   bfha_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORD_COUNT)) u_ram (
      .clock  (clock),
      .wr_en  (wr_req && wr_ok),
      .wr_addr(wr_byte[AW+1:2]),
      .wr_data(wr_word),
      .rd_addr(rd_byte[AW+1:2]),
      .rd_data(ram_q)
   );

   // reads outside the store return zero
   assign h     = rd_oob_ff ? '0 : ram_q;
   assign sz    = ADDR_W'({h[WORD_W-1:2], 2'b00});
   assign rd_ok = rd_byte < ADDR_W'(STORE_BYTES);
   assign wr_ok = wr_byte < ADDR_W'(STORE_BYTES);
   assign rest  = bsz_ff - need_ff;
   assign psz   = sz;
   assign nh    = h & ~WORD_W'(2);
   assign better = (sz > need_ff) && (!found_ff || (sz < bsz_ff));

   always_comb begin
      eff_cfg = ADDR_W'(csr_wr_data) & ~ADDR_W'(7);
      if (eff_cfg > ADDR_W'(CAP_BYTES)) begin
         eff_cfg = ADDR_W'(CAP_BYTES);
      end
      if (eff_cfg < ADDR_W'(16)) begin
         eff_cfg = ADDR_W'(16);
      end
   end

   always_comb begin
      heap_eff_in  = csr_wr_en ? eff_cfg : heap_eff_ff;
      fmt_cnt_in   = fmt_cnt_ff;
      cmd_in       = cmd_ff;
      req_zero_in  = req_zero_ff;
      ptr_in       = ptr_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      bsz_in       = bsz_ff;
      bhdr_in      = bhdr_ff;
      found_in     = found_ff;
      target_in    = target_ff;
      total_in     = total_ff;
      start_in     = start_ff;
      pbit_in      = pbit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in  = rsp_addr_ff;
      rd_byte      = cur_ff;
      wr_byte      = '0;
      wr_word      = '0;
      wr_req       = 1'b0;
      case (cmd.op)
         OP_FMT_CLR: begin
            wr_req     = 1'b1;
            wr_byte    = ADDR_W'({fmt_cnt_ff, 2'b00});
            fmt_cnt_in = fmt_cnt_ff + AW'(1);
         end
         OP_FMT_HDR: begin
            wr_req  = 1'b1;
            wr_byte = ADDR_W'(4);
            wr_word = WORD_W'(heap_eff_ff - ADDR_W'(8)) | WORD_W'(2);
         end
         OP_FMT_FTR: begin
            wr_req  = 1'b1;
            wr_byte = heap_eff_ff - ADDR_W'(8);
            wr_word = WORD_W'(heap_eff_ff - ADDR_W'(8));
         end
         OP_FMT_END: begin
            wr_req  = 1'b1;
            wr_byte = heap_eff_ff - ADDR_W'(4);
            wr_word = WORD_W'(1);
         end
         OP_LOAD: begin
            cmd_in      = in_cmd;
            req_zero_in = (in_req_bytes == '0);
            ptr_in      = ADDR_W'(in_payload_addr);
            need_in     = (ADDR_W'(in_req_bytes) + ADDR_W'(11)) & ~ADDR_W'(7);
            target_in   = ADDR_W'(in_payload_addr) - ADDR_W'(4);
            cur_in      = ADDR_W'(4);
            found_in    = 1'b0;
         end
         OP_RD_CUR: begin
            rd_byte = cur_ff;
         end
         OP_A_CHK: begin
            // next header is fetched while this one is judged
            rd_byte = cur_ff + sz;
            cur_in  = cur_ff + sz;
            if (!h[0] && ((sz == need_ff) || better)) begin
               best_in  = cur_ff;
               bsz_in   = sz;
               bhdr_in  = h;
               found_in = 1'b1;
            end
         end
         OP_SPL_HDR: begin
            wr_req  = 1'b1;
            wr_byte = best_ff;
            wr_word = WORD_W'(need_ff) | (bhdr_ff & WORD_W'(2)) | WORD_W'(1);
         end
         OP_SPL_REST: begin
            wr_req  = 1'b1;
            wr_byte = best_ff + need_ff;
            wr_word = WORD_W'(rest) | WORD_W'(2);
         end
         OP_SPL_FTR: begin
            wr_req  = 1'b1;
            wr_byte = best_ff + bsz_ff - ADDR_W'(4);
            wr_word = WORD_W'(rest);
         end
         OP_WR_BEST: begin
            wr_req  = 1'b1;
            wr_byte = best_ff;
            wr_word = bhdr_ff | WORD_W'(1);
         end
         OP_RD_ANX: begin
            rd_byte = best_ff + bsz_ff;
         end
         OP_WR_ANX: begin
            wr_req  = (h != WORD_W'(1));
            wr_byte = best_ff + bsz_ff;
            wr_word = h | WORD_W'(2);
         end
         OP_F_CHK: begin
            rd_byte = cur_ff + sz;
            cur_in  = cur_ff + sz;
            if (cur_ff == target_ff) begin
               bhdr_in  = h;
               total_in = sz;
               pbit_in  = h[1];
               start_in = target_ff;
            end
         end
         OP_RD_FNX: begin
            rd_byte = target_ff + total_ff;
         end
         OP_F_NCHK: begin
            if (h != WORD_W'(1)) begin
               wr_req  = 1'b1;
               wr_byte = target_ff + ADDR_W'({bhdr_ff[WORD_W-1:2], 2'b00});
               wr_word = nh;
               if (!nh[0]) begin
                  total_in = total_ff + sz;
               end
            end
         end
         OP_RD_PFTR: begin
            rd_byte = target_ff - ADDR_W'(4);
         end
         OP_F_PCHK: begin
            if (status.prev_merge) begin
               start_in = target_ff - psz;
               total_in = total_ff + psz;
            end else begin
               pbit_in = 1'b0;
            end
         end
         OP_RD_START: begin
            rd_byte = start_ff;
         end
         OP_F_PBIT: begin
            pbit_in = h[1];
         end
         OP_WR_START: begin
            wr_req  = 1'b1;
            wr_byte = start_ff;
            wr_word = WORD_W'(total_ff) | (pbit_ff ? WORD_W'(2) : WORD_W'(0));
         end
         OP_WR_SFTR: begin
            wr_req  = 1'b1;
            wr_byte = start_ff + total_ff - ADDR_W'(4);
            wr_word = WORD_W'(total_ff);
         end
         OP_RESULT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.res_status;
            rsp_addr_in   = ((cmd.res_status == ST_OK) && !cmd_ff) ?
                            RES_ADDR_W'(best_ff + ADDR_W'(4)) : '0;
         end
         default: begin
         end
      endcase
      if (csr_wr_en) begin
         fmt_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_eff_ff  <= ADDR_W'(CAP_BYTES);
         fmt_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         heap_eff_ff  <= heap_eff_in;
         fmt_cnt_ff   <= fmt_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      req_zero_ff   <= req_zero_in;
      ptr_ff        <= ptr_in;
      need_ff       <= need_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      bsz_ff        <= bsz_in;
      bhdr_ff       <= bhdr_in;
      found_ff      <= found_in;
      target_ff     <= target_in;
      total_ff      <= total_in;
      start_ff      <= start_in;
      pbit_ff       <= pbit_in;
      rd_oob_ff     <= !rd_ok;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   always_comb begin
      status.req_zero   = req_zero_ff;
      status.ptr_bad    = (ptr_ff == '0) || (ptr_ff[2:0] != 3'd0) ||
                          ((ptr_ff + ADDR_W'(4)) > heap_eff_ff);
      status.cmd_free   = cmd_ff;
      status.walk_stop  = (h == WORD_W'(1)) || (sz == '0);
      status.blk_free   = !h[0];
      status.exact      = (sz == need_ff);
      status.cur_gt     = cur_ff > target_ff;
      status.cur_eq     = cur_ff == target_ff;
      status.found      = found_ff;
      status.split      = rest >= ADDR_W'(8);
      status.prev_merge = (psz != '0) && (psz <= (target_ff - ADDR_W'(4)));
      status.pbit_zero  = !pbit_ff;
      status.fmt_last   = (fmt_cnt_ff == AW'(HEAP_WORD_COUNT - 1));
      status.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;

endmodule

FILE: src/bfha_ctrl.sv
// Allocator controller: sequences format, best-fit walk, split, free and coalesce.
// Depends on bfha_pkg.
module bfha_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bfha_pkg::dp_status_type status,
   output bfha_pkg::dp_cmd_type    cmd
);
   import bfha_pkg::*;

   localparam logic [4:0] S_FMT_CLR  = 5'd0;
   localparam logic [4:0] S_FMT_HDR  = 5'd1;
   localparam logic [4:0] S_FMT_FTR  = 5'd2;
   localparam logic [4:0] S_FMT_END  = 5'd3;
   localparam logic [4:0] S_IDLE     = 5'd4;
   localparam logic [4:0] S_START    = 5'd5;
   localparam logic [4:0] S_A_CHK    = 5'd6;
   localparam logic [4:0] S_A_END    = 5'd7;
   localparam logic [4:0] S_SPL_REST = 5'd8;
   localparam logic [4:0] S_SPL_FTR  = 5'd9;
   localparam logic [4:0] S_ANX_RD   = 5'd10;
   localparam logic [4:0] S_ANX_WR   = 5'd11;
   localparam logic [4:0] S_F_CHK    = 5'd12;
   localparam logic [4:0] S_F_NRD    = 5'd13;
   localparam logic [4:0] S_F_NCHK   = 5'd14;
   localparam logic [4:0] S_F_PRD    = 5'd15;
   localparam logic [4:0] S_F_PCHK   = 5'd16;
   localparam logic [4:0] S_F_SRD    = 5'd17;
   localparam logic [4:0] S_F_PBIT   = 5'd18;
   localparam logic [4:0] S_F_WS     = 5'd19;
   localparam logic [4:0] S_F_WF     = 5'd20;
   localparam logic [4:0] S_RESULT   = 5'd21;

   logic [4:0]      state_ff, state_in;
   logic [ST_W-1:0] res_ff, res_in;

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      cmd.op   = OP_NONE;
      cmd.res_status = res_ff;
      case (state_ff)
         S_FMT_CLR: begin
            cmd.op = OP_FMT_CLR;
            if (status.fmt_last) begin
               state_in = S_FMT_HDR;
            end
         end
         S_FMT_HDR: begin
            cmd.op   = OP_FMT_HDR;
            state_in = S_FMT_FTR;
         end
         S_FMT_FTR: begin
            cmd.op   = OP_FMT_FTR;
            state_in = S_FMT_END;
         end
         S_FMT_END: begin
            cmd.op   = OP_FMT_END;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            if (status.cmd_free) begin
               if (status.ptr_bad) begin
                  res_in   = ST_BAD_PTR;
                  state_in = S_RESULT;
               end else begin
                  cmd.op   = OP_RD_CUR;
                  state_in = S_F_CHK;
               end
            end else if (status.req_zero) begin
               res_in   = ST_BAD_SIZE;
               state_in = S_RESULT;
            end else begin
               cmd.op   = OP_RD_CUR;
               state_in = S_A_CHK;
            end
         end
         S_A_CHK: begin
            cmd.op = OP_A_CHK;
            if (status.walk_stop) begin
               cmd.op   = OP_NONE;
               state_in = S_A_END;
            end else if (status.blk_free && status.exact) begin
               state_in = S_A_END;
            end
         end
         S_A_END: begin
            if (!status.found) begin
               res_in   = ST_NO_FIT;
               state_in = S_RESULT;
            end else if (status.split) begin
               cmd.op   = OP_SPL_HDR;
               state_in = S_SPL_REST;
            end else begin
               cmd.op   = OP_WR_BEST;
               state_in = S_ANX_RD;
            end
         end
         S_SPL_REST: begin
            cmd.op   = OP_SPL_REST;
            state_in = S_SPL_FTR;
         end
         S_SPL_FTR: begin
            cmd.op   = OP_SPL_FTR;
            res_in   = ST_OK;
            state_in = S_RESULT;
         end
         S_ANX_RD: begin
            cmd.op   = OP_RD_ANX;
            state_in = S_ANX_WR;
         end
         S_ANX_WR: begin
            cmd.op   = OP_WR_ANX;
            res_in   = ST_OK;
            state_in = S_RESULT;
         end
         S_F_CHK: begin
            cmd.op = OP_F_CHK;
            if (status.walk_stop || status.cur_gt) begin
               cmd.op   = OP_NONE;
               res_in   = ST_BAD_PTR;
               state_in = S_RESULT;
            end else if (status.cur_eq) begin
               if (status.blk_free) begin
                  res_in   = ST_ALREADY_FREE;
                  state_in = S_RESULT;
               end else begin
                  state_in = S_F_NRD;
               end
            end
         end
         S_F_NRD: begin
            cmd.op   = OP_RD_FNX;
            state_in = S_F_NCHK;
         end
         S_F_NCHK: begin
            cmd.op   = OP_F_NCHK;
            state_in = status.pbit_zero ? S_F_PRD : S_F_WS;
         end
         S_F_PRD: begin
            cmd.op   = OP_RD_PFTR;
            state_in = S_F_PCHK;
         end
         S_F_PCHK: begin
            cmd.op   = OP_F_PCHK;
            state_in = status.prev_merge ? S_F_SRD : S_F_WS;
         end
         S_F_SRD: begin
            cmd.op   = OP_RD_START;
            state_in = S_F_PBIT;
         end
         S_F_PBIT: begin
            cmd.op   = OP_F_PBIT;
            state_in = S_F_WS;
         end
         S_F_WS: begin
            cmd.op   = OP_WR_START;
            state_in = S_F_WF;
         end
         S_F_WF: begin
            cmd.op   = OP_WR_SFTR;
            res_in   = ST_OK;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!status.out_busy) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a size write reformats the store from scratch
      if (csr_wr_en) begin
         cmd.op   = OP_NONE;
         state_in = S_FMT_CLR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FMT_CLR;
      end else begin
         state_ff <= state_in;
      end
      res_ff <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !csr_wr_en;

endmodule

FILE: src/best_fit_heap_allocator_unit.sv
// Top level of the best-fit heap allocator: controller plus datapath.
// Depends on bfha_pkg, bfha_ctrl, bfha_datapath (and bfha_ram below it).
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser: cmd; tdata: req_bytes, payload_addr
//  rsp      out  rsp_tvalid/rsp_tready  tdata: status, result_addr
//  csr      in   csr_wr_en              csr_wr_data: heap_bytes
//
// One transaction at a time. Block headers are read one per cycle from the
// single RAM read port, the end mark included unless an exact fit stops the
// walk; a free runs extra read and write steps depending on merges, and a bad
// size or bad pointer caught up front skips the walk. The unit returns to idle
// between transactions.
// Reset and every csr write run a clearing pass over all 4096 words plus 3
// format writes; req_tready stays low meanwhile.
// The result sits in an output register; a stalled rsp holds the unit only once
// the next result is ready.
module best_fit_heap_allocator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] cmd
   input  logic                               req_tuser,
   // [14:0] req_bytes, [28:15] payload_addr, [31:29] zero
   input  logic [bfha_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] status, [16:3] result_addr, [23:17] zero
   output logic [bfha_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [bfha_pkg::CFG_W-1:0]         csr_wr_data
);
   import bfha_pkg::*;

   dp_cmd_type            dp_cmd;
   dp_status_type         dp_status;
   logic [ST_W-1:0]       rsp_status;
   logic [RES_ADDR_W-1:0] rsp_result_addr;

   bfha_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .status   (dp_status),
      .cmd      (dp_cmd)
   );

   bfha_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .in_cmd         (req_tuser),
      .in_req_bytes   (req_tdata[14:0]),
      .in_payload_addr(req_tdata[28:15]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_result_addr(rsp_result_addr)
   );

   // pack result transaction, zero fill to whole bytes
   assign rsp_tdata = {7'd0, rsp_result_addr, rsp_status};

endmodule

FILE: src/bfha_checker.sv
// Port-level checker for the best-fit heap allocator, bound to the top level.
// Depends on bfha_pkg.
module bfha_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bfha_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            csr_wr_en
);
   import bfha_pkg::*;

   a_reset_formats: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("req_tready high right after reset");

   a_csr_formats: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_tready)
      else $error("req_tready high right after csr write");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction taken while one is in work");

   a_err_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] != ST_OK)) |-> (rsp_tdata[16:3] == '0))
      else $error("failed result carries an address");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind best_fit_heap_allocator_unit bfha_checker u_bfha_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .csr_wr_en (csr_wr_en)
);

FILE: tb/sv/best_fit_heap_allocator_unit_tb.sv
// Self-checking testbench for best_fit_heap_allocator_unit: directed table, then
// random allocate/free traffic checked against an in-bench heap predictor.
// Depends on bfha_pkg and the allocator RTL only.
module best_fit_heap_allocator_unit_tb;
   import bfha_pkg::*;

   localparam int STALL_LIMIT = 40000;   // > clearing pass + longest walk + hold-off
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 60;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic                  req_tuser;   // [0] cmd
   logic [REQ_DATA_W-1:0] req_tdata;   // [14:0] req_bytes, [28:15] payload_addr
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [2:0] status, [16:3] result_addr
   logic                  csr_wr_en;
   logic [CFG_W-1:0]      csr_wr_data;

   best_fit_heap_allocator_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   typedef struct packed {
      logic [ST_W-1:0]       status;
      logic [RES_ADDR_W-1:0] addr;
   } alloc_rsp_type;

   typedef struct {
      bit                    typed;   // expected result written in the row
      bit                    cmd;
      int unsigned           nbytes;
      int unsigned           ptr;
      logic [ST_W-1:0]       status;
      logic [RES_ADDR_W-1:0] addr;
   } heap_row_type;

   // heap mirror
   int unsigned heap_mem [HEAP_WORD_COUNT];
   int unsigned heap_size;
   int unsigned heap_used_bytes;   // saturated region size

   alloc_rsp_type pending_rsp_q[$];
   int unsigned live_ptrs[$];      // payload offsets currently allocated
   int          err_cnt;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_req;
   int          hold_cnt;
   int          quiet_cycles;

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic int unsigned mem_rd(int unsigned b);
      return ((b >> 2) < HEAP_WORD_COUNT) ? heap_mem[b >> 2] : 0;
   endfunction

   function automatic void mem_wr(int unsigned b, int unsigned v);
      if ((b >> 2) < HEAP_WORD_COUNT) heap_mem[b >> 2] = v;
   endfunction

   function automatic void heap_format(int unsigned cfg);
      int unsigned e;
      e = cfg & ~32'd7;
      if (e > CAP_BYTES) e = CAP_BYTES;
      if (e < 16) e = 16;
      heap_used_bytes = e;
      foreach (heap_mem[i]) heap_mem[i] = 0;
      mem_wr(4, (e - 8) | 2);
      mem_wr(4 + e - 12, e - 8);
      mem_wr(e - 4, 1);
      live_ptrs.delete();
   endfunction

   // best-fit search with early stop on exact size, split when rest >= 8
   function automatic alloc_rsp_type heap_alloc(int unsigned nbytes);
      alloc_rsp_type r;
      int unsigned need, cur, best, best_sz, steps, h, sz, rest, nx;
      bit          found;
      r = '0;
      if (nbytes == 0) begin
         r.status = ST_BAD_SIZE;
         return r;
      end
      need = (nbytes + 11) & ~32'd7;
      cur = 4; best = 0; best_sz = 0; steps = 0; found = 0;
      while (steps < HEAP_WORD_COUNT) begin
         h = mem_rd(cur);
         sz = h & ~32'd3;
         if (h == 1 || sz == 0) break;
         if ((h & 1) == 0) begin
            if (sz == need) begin
               best = cur; best_sz = sz; found = 1;
               break;
            end
            if (sz > need && (!found || sz < best_sz)) begin
               best = cur; best_sz = sz; found = 1;
            end
         end
         cur += sz;
         steps++;
      end
      if (!found) begin
         r.status = ST_NO_FIT;
         return r;
      end
      if (best_sz - need >= 8) begin
         rest = best_sz - need;
         mem_wr(best, need | (mem_rd(best) & 2) | 1);
         mem_wr(best + need, rest | 2);
         mem_wr(best + need + rest - 4, rest);
      end else begin
         nx = best + best_sz;
         mem_wr(best, mem_rd(best) | 1);
         if (mem_rd(nx) != 1) mem_wr(nx, mem_rd(nx) | 2);
      end
      r.status = ST_OK;
      r.addr   = RES_ADDR_W'(best + 4);
      live_ptrs.push_back(best + 4);
      return r;
   endfunction

   // pointer check, then coalesce with free neighbors on both sides
   function automatic alloc_rsp_type heap_free(int unsigned ptr);
      alloc_rsp_type r;
      int unsigned tgt, cur, steps, h, sz, nh, start, total, pbit, psz;
      bit          hit;
      r = '0;
      r.status = ST_BAD_PTR;
      if (ptr == 0 || (ptr & 7) != 0) return r;
      if (ptr > 4 + heap_used_bytes - 8) return r;
      tgt = ptr - 4; cur = 4; steps = 0; hit = 0;
      while (steps < HEAP_WORD_COUNT) begin
         h = mem_rd(cur);
         sz = h & ~32'd3;
         if (h == 1 || sz == 0 || cur > tgt) break;
         if (cur == tgt) begin
            hit = 1;
            break;
         end
         cur += sz;
         steps++;
      end
      if (!hit) return r;
      h = mem_rd(tgt);
      if ((h & 1) == 0) begin
         r.status = ST_ALREADY_FREE;
         return r;
      end
      sz = h & ~32'd3;
      pbit = h & 2;
      start = tgt;
      total = sz;
      nh = mem_rd(tgt + sz);
      if (nh != 1) begin
         nh &= ~32'd2;
         mem_wr(tgt + sz, nh);
         if ((nh & 1) == 0) total += nh & ~32'd3;
      end
      if (pbit == 0) begin
         psz = mem_rd(tgt - 4) & ~32'd3;
         if (psz != 0 && psz <= tgt - 4) begin
            start = tgt - psz;
            total += psz;
            pbit = mem_rd(start) & 2;
         end else begin
            pbit = 0;
         end
      end
      mem_wr(start, total | pbit);
      mem_wr(start + total - 4, total);
      r.status = ST_OK;
      foreach (live_ptrs[i]) begin
         if (live_ptrs[i] == ptr) begin
            live_ptrs.delete(i);
            break;
         end
      end
      return r;
   endfunction

   // one request transaction; the returned value is the predicted response
   task automatic send_cmd(bit cmd, int unsigned nbytes, int unsigned ptr,
                           output alloc_rsp_type pred);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser  = cmd;
      req_tdata  = {3'b000, PTR_W'(ptr), REQ_W'(nbytes)};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pred = cmd ? heap_free(ptr & 32'h3FFF) : heap_alloc(nbytes & 32'h7FFF);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic drain();
      wait (pending_rsp_q.size() == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // reformat: only with nothing in flight
   task automatic write_heap_size(int unsigned v);
      drain();
      csr_wr_data = CFG_W'(v);
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      heap_format(v);
   endtask

   task automatic random_cmd();
      alloc_rsp_type pred;
      int unsigned r, nbytes, ptr;
      r = $urandom_range(99);
      if (r < 55) begin
         if (r < 2)       nbytes = 0;
         else if (r < 5)  nbytes = $urandom_range(32'h7FFF);
         else if (r < 12) nbytes = $urandom_range(1, heap_used_bytes);
         else             nbytes = $urandom_range(1, 64);
         send_cmd(1'b0, nbytes, $urandom_range(16383), pred);
      end else if (r < 90 && live_ptrs.size() > 0) begin
         ptr = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
         send_cmd(1'b1, $urandom_range(32'h7FFF), ptr, pred);
      end else if (r < 95) begin
         send_cmd(1'b1, 0, $urandom_range(16383), pred);
      end else begin
         ptr = $urandom_range(heap_used_bytes) & ~32'd7;   // aligned, likely mid-block
         send_cmd(1'b1, 0, ptr, pred);
      end
      pending_rsp_q.push_back(pred);
   endtask

   // response check against oldest pending prediction
   always @(posedge clock) begin
      alloc_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[ST_W-1:0];
         got.addr   = rsp_tdata[ST_W+RES_ADDR_W-1:ST_W];
         if (pending_rsp_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10) $display("unexpected response: status %0d addr %0d",
                                        got.status, got.addr);
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.status != want.status || got.addr != want.addr) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display("mismatch: status exp %0d got %0d, addr exp %0d got %0d",
                           want.status, got.status, want.addr, got.addr);
            end
         end
      end
   end

   // response side backpressure, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      heap_row_type  dir_tab[];
      alloc_rsp_type pred;
      int unsigned phase_cfg[4];
      int          n;

      reset = 1'b1; req_tvalid = 1'b0; req_tuser = 1'b0; req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0; csr_wr_data = '0;
      err_cnt = 0; send_idle_pct = 0; recv_stall_pct = 0;
      hold_req = 1'b0; hold_cnt = 0; quiet_cycles = 0;
      heap_format(16384);

      // typed rows: default 16384-byte heap, first header at byte 4
      dir_tab = '{
         '{1, 0, 0,      0,     ST_BAD_SIZE,     0},   // zero request
         '{1, 0, 16384,  0,     ST_NO_FIT,       0},   // larger than the heap
         '{1, 1, 0,      0,     ST_BAD_PTR,      0},
         '{1, 1, 0,      12,    ST_BAD_PTR,      0},   // unaligned
         '{1, 1, 0,      16383, ST_BAD_PTR,      0},   // past the heap end
         '{1, 0, 1,      0,     ST_OK,           8},
         '{1, 0, 12,     0,     ST_OK,           16},
         '{1, 1, 0,      8,     ST_OK,           0},
         '{1, 1, 0,      8,     ST_ALREADY_FREE, 0},   // double free
         '{1, 1, 0,      24,    ST_BAD_PTR,      0},   // inside a block
         '{1, 0, 4,      0,     ST_OK,           8},   // exact fit in the hole
         '{1, 1, 0,      16,    ST_OK,           0},   // merge with free next
         '{1, 1, 0,      8,     ST_OK,           0},
         '{1, 0, 16372,  0,     ST_OK,           8},   // whole heap, exact
         '{1, 0, 1,      0,     ST_NO_FIT,       0},   // heap full
         '{1, 1, 0,      8,     ST_OK,           0},
         '{1, 0, 32767,  0,     ST_NO_FIT,       0},   // all request bits set
         '{0, 0, 24,     0,     ST_OK,           0},
         '{0, 0, 24,     0,     ST_OK,           0},
         '{0, 0, 24,     0,     ST_OK,           0},
         '{0, 1, 32767,  40,    ST_OK,           0},
         '{0, 1, 0,      8,     ST_OK,           0},
         '{0, 1, 0,      72,    ST_OK,           0},   // merge on both sides
         '{0, 1, 0,      16376, ST_OK,           0}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) begin
         send_cmd(dir_tab[i].cmd, dir_tab[i].nbytes, dir_tab[i].ptr, pred);
         if (dir_tab[i].typed) begin
            pred.status = dir_tab[i].status;
            pred.addr   = dir_tab[i].addr;
         end
         pending_rsp_q.push_back(pred);
      end

      // phases: size setting with idle / stall mix; 0 and 32767 saturate
      phase_cfg = '{0, 200, 32767, 1000};
      for (int p = 0; p < 4; p++) begin
         write_heap_size(phase_cfg[p]);
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         n = (p == 0) ? 60 : 115;
         for (int k = 0; k < n; k++) begin
            if (p == 2 && k == 20) hold_req = 1'b1;   // fill up behind a stalled rsp
            if (p == 3 && k == 50) wait (pending_rsp_q.size() == 0);
            random_cmd();
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (err_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
